// ----- hdl/mbr_pkg.sv -----
// Shared types, register indexes and defaults for the bitmap rotate raster block.
package mbr_pkg;

  localparam int DEF_MAX_WIDTH_PX  = 4096;
  localparam int DEF_MAX_HEIGHT_PX = 4096;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PX       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_PX      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LANDSCAPE_MODE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_WIDTH_PX  = 13'd1200;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT_PX = 13'd1575;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [3:0] STEPS_LANDSCAPE = 4'd8;
  localparam logic [3:0] STEPS_PORTRAIT  = 4'd1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] raster_byte;
    logic       end_of_line;
    logic       end_of_image;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_READ,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    AGU_HOLD,
    AGU_LOAD,
    AGU_ADD
  } agu_op_t;

endpackage

// ----- hdl/mbr_store.sv -----
// Single-port page memory with registered read data.
module mbr_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hdl/mbr_agu.sv -----
// Shared address accumulator: load pointer, portrait read pointer and row stepper.
module mbr_agu #(
  parameter int XW = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  mbr_pkg::agu_op_t op,
  input  logic [XW-1:0]   load_value,
  input  logic [XW-1:0]   inc,
  output logic [XW-1:0]   addr
);

  logic [XW-1:0] addr_next;

  always_comb begin
    case (op)
      mbr_pkg::AGU_LOAD: addr_next = load_value;
      mbr_pkg::AGU_ADD:  addr_next = addr + inc;
      default:           addr_next = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      addr <= addr_next;
    end
  end

endmodule

// ----- hdl/mono_bitmap_rotate_raster_out.sv -----
// Top level: one-bit page store with portrait or rotated raster read-out.
// A load item is accepted, then written with one memory write. A read item is accepted, its
// address is set up, then one memory read per cycle is made on the single store port (one for
// portrait, eight stored rows for landscape), the last read data is captured, and the result is
// placed in the output register once the output is free. The store, the load pointer and the row
// addresses all share one address accumulator. Read items before the page is fully loaded, and
// load items after it, give no result. The store needs no clearing after reset.
module mono_bitmap_rotate_raster_out #(
  parameter int MAX_WIDTH_PX  = mbr_pkg::DEF_MAX_WIDTH_PX,
  parameter int MAX_HEIGHT_PX = mbr_pkg::DEF_MAX_HEIGHT_PX
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mbr_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mbr_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [mbr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WW      = $clog2(MAX_WIDTH_PX + 1);
  localparam int HW      = $clog2(MAX_HEIGHT_PX + 1);
  localparam int MAX_BPL = (MAX_WIDTH_PX + 7) / 8;
  localparam int MAX_BPH = (MAX_HEIGHT_PX + 7) / 8;
  localparam int DEPTH   = MAX_HEIGHT_PX * MAX_BPL;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = AW + 1;
  localparam int MAX_LB  = (MAX_BPL > MAX_BPH) ? MAX_BPL : MAX_BPH;
  localparam int BW      = ($clog2(MAX_LB) > 0) ? $clog2(MAX_LB) : 1;
  localparam int MAX_DIM = (MAX_WIDTH_PX > MAX_HEIGHT_PX) ? MAX_WIDTH_PX : MAX_HEIGHT_PX;
  localparam int LW      = $clog2(MAX_DIM);
  localparam int BPW     = $clog2(MAX_BPL + 1);
  localparam int DW0     = (WW > HW) ? WW : HW;
  localparam int NW      = ((DW0 > mbr_pkg::CFG_DATA_W) ? DW0 : mbr_pkg::CFG_DATA_W) + 1;

  logic [mbr_pkg::CFG_DATA_W-1:0] cfg_width;
  logic [mbr_pkg::CFG_DATA_W-1:0] cfg_height;
  logic                           landscape;

  mbr_pkg::state_t  state;
  mbr_pkg::state_t  state_next;
  mbr_pkg::agu_op_t agu_op;
  logic [XW-1:0]    agu_load_value;
  logic [XW-1:0]    agu_inc;
  logic [XW-1:0]    addr;

  logic             full;
  logic [LW-1:0]    line_idx;
  logic [BW-1:0]    byte_idx;
  logic [3:0]       step;
  logic [3:0]       last_step;
  logic [7:0]       acc;
  logic [7:0]       pixel;
  logic             row_ok;
  logic [XW-1:0]    tot_m1;

  logic             mem_en;
  logic             mem_we;
  logic [7:0]       rdata;

  logic [NW-1:0]    w_ext;
  logic [NW-1:0]    h_ext;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [WW-1:0]    w_m1;
  logic [HW-1:0]    h_m1;
  logic [BPW-1:0]   bpl;
  logic [NW-1:0]    lines_m1;
  logic [NW-1:0]    lb_m1;
  logic             eol;
  logic             eoi;
  logic [WW-1:0]    col;
  logic [XW-1:0]    xbyte;
  logic [2:0]       bitsel;
  logic [BW+2:0]    row;
  logic             out_free;
  logic             restart_cfg;

  always_comb begin
    w_ext = NW'(cfg_width);
    h_ext = NW'(cfg_height);
    if (w_ext == '0) begin
      eff_w = WW'(1);
    end else if (w_ext > NW'(MAX_WIDTH_PX)) begin
      eff_w = WW'(MAX_WIDTH_PX);
    end else begin
      eff_w = WW'(w_ext);
    end
    if (h_ext == '0) begin
      eff_h = HW'(1);
    end else if (h_ext > NW'(MAX_HEIGHT_PX)) begin
      eff_h = HW'(MAX_HEIGHT_PX);
    end else begin
      eff_h = HW'(h_ext);
    end
  end

  assign w_m1      = eff_w - WW'(1);
  assign h_m1      = eff_h - HW'(1);
  assign bpl       = BPW'(w_m1 >> 3) + BPW'(1);
  assign lines_m1  = landscape ? NW'(w_m1) : NW'(h_m1);
  assign lb_m1     = landscape ? NW'(h_m1 >> 3) : NW'(w_m1 >> 3);
  assign eol       = NW'(byte_idx) >= lb_m1;
  assign eoi       = eol && (NW'(line_idx) >= lines_m1);
  assign col       = w_m1 - WW'(line_idx);
  assign xbyte     = XW'(col >> 3);
  assign bitsel    = col[2:0];
  assign row       = {byte_idx, step[2:0]};
  assign last_step = landscape ? mbr_pkg::STEPS_LANDSCAPE : mbr_pkg::STEPS_PORTRAIT;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == mbr_pkg::S_IDLE);

  assign restart_cfg = cfg_we && (cfg_index == mbr_pkg::REG_WIDTH_PX ||
                                  cfg_index == mbr_pkg::REG_HEIGHT_PX ||
                                  cfg_index == mbr_pkg::REG_LANDSCAPE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= mbr_pkg::RST_WIDTH_PX;
      cfg_height <= mbr_pkg::RST_HEIGHT_PX;
      landscape  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbr_pkg::REG_WIDTH_PX:       cfg_width  <= cfg_data;
        mbr_pkg::REG_HEIGHT_PX:      cfg_height <= cfg_data;
        mbr_pkg::REG_LANDSCAPE_MODE: landscape  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tot_m1 <= XW'(XW'(eff_h) * XW'(bpl)) - XW'(1);
  end

  always_comb begin
    state_next     = state;
    agu_op         = mbr_pkg::AGU_HOLD;
    agu_load_value = '0;
    agu_inc        = XW'(1);
    mem_en         = 1'b0;
    mem_we         = 1'b0;
    case (state)
      mbr_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == mbr_pkg::REQ_LOAD) begin
            state_next = full ? mbr_pkg::S_IDLE : mbr_pkg::S_LOAD;
          end else begin
            state_next = full ? mbr_pkg::S_START : mbr_pkg::S_IDLE;
          end
        end
      end
      mbr_pkg::S_LOAD: begin
        mem_en     = 1'b1;
        mem_we     = 1'b1;
        agu_op     = mbr_pkg::AGU_ADD;
        state_next = mbr_pkg::S_IDLE;
      end
      mbr_pkg::S_START: begin
        if (landscape) begin
          if (byte_idx == '0) begin
            agu_op         = mbr_pkg::AGU_LOAD;
            agu_load_value = xbyte;
          end
        end else if (line_idx == '0 && byte_idx == '0) begin
          agu_op = mbr_pkg::AGU_LOAD;
        end
        state_next = mbr_pkg::S_READ;
      end
      mbr_pkg::S_READ: begin
        if (step < last_step) begin
          mem_en  = 1'b1;
          agu_op  = mbr_pkg::AGU_ADD;
          agu_inc = landscape ? XW'(bpl) : XW'(1);
        end else begin
          state_next = mbr_pkg::S_DONE;
        end
      end
      mbr_pkg::S_DONE: begin
        if (out_free) begin
          if (eoi) begin
            agu_op = mbr_pkg::AGU_LOAD;
          end
          state_next = mbr_pkg::S_IDLE;
        end
      end
      default: state_next = mbr_pkg::S_IDLE;
    endcase
    if (restart_cfg) begin
      agu_op         = mbr_pkg::AGU_LOAD;
      agu_load_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full      <= 1'b0;
      line_idx  <= '0;
      byte_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == mbr_pkg::S_LOAD && addr >= tot_m1) begin
        full <= 1'b1;
      end
      if (state == mbr_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
        if (eoi) begin
          full     <= 1'b0;
          line_idx <= '0;
          byte_idx <= '0;
        end else if (eol) begin
          byte_idx <= '0;
          line_idx <= line_idx + LW'(1);
        end else begin
          byte_idx <= byte_idx + BW'(1);
        end
      end
      if (restart_cfg) begin
        full     <= 1'b0;
        line_idx <= '0;
        byte_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mbr_pkg::S_IDLE && in_valid) begin
      pixel <= in_data.pixel_byte;
    end
    if (state == mbr_pkg::S_START) begin
      step <= '0;
      acc  <= '0;
    end
    if (state == mbr_pkg::S_READ) begin
      step   <= step + 4'd1;
      row_ok <= NW'(row) < NW'(eff_h);
      if (step != '0) begin
        if (landscape) begin
          acc <= {acc[6:0], row_ok & rdata[3'd7 - bitsel]};
        end else begin
          acc <= rdata;
        end
      end
    end
    if (state == mbr_pkg::S_DONE && out_free) begin
      out_data.raster_byte  <= acc;
      out_data.end_of_line  <= eol;
      out_data.end_of_image <= eoi;
    end
  end

  mbr_agu #(
    .XW(XW)
  ) u_agu (
    .clk       (clk),
    .rst       (rst),
    .op        (agu_op),
    .load_value(agu_load_value),
    .inc       (agu_inc),
    .addr      (addr)
  );

  mbr_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (addr[AW-1:0]),
    .wdata(pixel),
    .rdata(rdata)
  );

endmodule
